>>> rtl/rect_atlas_allocator_defines.svh
// Assertion macros shared by the rect atlas allocator RTL.
// No dependencies; included by files that carry assertions.
`ifndef RECT_ATLAS_ALLOCATOR_DEFINES_SVH
`define RECT_ATLAS_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define RAA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/raa_pkg.sv
// Shared constants and types of the rect atlas allocator.
// No dependencies.
package raa_pkg;

    localparam int DIM_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_FREE   = 64;
    localparam int DEF_COORD_BITS = 12;

    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

>>> rtl/raa_intf.sv
// Handshake interfaces of the rect atlas allocator: request, response, config.
// Depends on raa_pkg.
interface raa_req_if import raa_pkg::*;;
    logic             valid;
    logic             ready;
    logic             command;
    logic [DIM_W-1:0] req_width;
    logic [DIM_W-1:0] req_height;

    modport source (output valid, command, req_width, req_height, input ready);
    modport sink   (input valid, command, req_width, req_height, output ready);
endinterface

interface raa_rsp_if import raa_pkg::*; #(parameter int COORD_BITS = DEF_COORD_BITS);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [COORD_BITS-1:0] place_x;
    logic [COORD_BITS-1:0] place_y;

    modport source (output valid, status, place_x, place_y, input ready);
    modport sink   (input valid, status, place_x, place_y, output ready);
endinterface

interface raa_cfg_if import raa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/raa_mem.sv
// Free rectangle list storage: one write port, one registered read port.
// Depends on raa_pkg.
module raa_mem import raa_pkg::*; #(
    parameter int DEPTH = DEF_MAX_FREE,
    parameter int DW    = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/raa_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on raa_pkg.
module raa_mul import raa_pkg::*; #(
    parameter int W = DIM_W
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p <= a * b;
        end
    end

endmodule

>>> rtl/rect_atlas_allocator.sv
// Rect atlas allocator: guillotine split, best-area fit over a free list.
// Clear and refused zero-size requests go straight to the response; an allocate
// scans the free list, splits the best entry, removes it, appends pieces and merges.
// One request at a time; not ready until the response is registered.
// After reset the S_INIT state writes the initial free entry before the first request.
// Depends on raa_pkg, raa_intf, raa_mem, raa_mul, rect_atlas_allocator_defines.svh.
`include "rect_atlas_allocator_defines.svh"

module rect_atlas_allocator import raa_pkg::*; #(
    parameter int MAX_FREE_RECTS = DEF_MAX_FREE,
    parameter int COORD_BITS     = DEF_COORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    raa_req_if.sink   req,
    raa_rsp_if.source rsp,
    raa_cfg_if.sink   cfg
);

    localparam int FW = COORD_BITS + 1;
    localparam int CW = (FW > DIM_W) ? FW : DIM_W;
    localparam int PW = 2 * CW;
    localparam int IW = $clog2(MAX_FREE_RECTS);
    localparam int NW = $clog2(MAX_FREE_RECTS + 1);
    localparam int EB = 4 * FW;

    typedef struct packed {
        logic [FW-1:0] x;
        logic [FW-1:0] y;
        logic [FW-1:0] w;
        logic [FW-1:0] h;
    } ent_t;

    typedef enum logic [16:0] {
        S_INIT     = 17'h00001,
        S_IDLE     = 17'h00002,
        S_SCAN_RD  = 17'h00004,
        S_SCAN_MUL = 17'h00008,
        S_SCAN_CMP = 17'h00010,
        S_HOR1     = 17'h00020,
        S_HOR2     = 17'h00040,
        S_HOR3     = 17'h00080,
        S_DROP_RD  = 17'h00100,
        S_DROP_WR  = 17'h00200,
        S_APPEND   = 17'h00400,
        S_MI_RD    = 17'h00800,
        S_MI_LD    = 17'h01000,
        S_MJ_RD    = 17'h02000,
        S_MJ_EV    = 17'h04000,
        S_MI_WB    = 17'h08000,
        S_DONE     = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] atlas_w_reg, atlas_h_reg;
    logic [NW-1:0]    count_reg, count_next;
    logic [NW-1:0]    k_reg, k_next;
    logic [NW-1:0]    best_idx_reg, best_idx_next;
    logic [NW-1:0]    drop_t_reg, drop_t_next;
    logic [NW-1:0]    i_reg, i_next;
    logic [NW-1:0]    j_reg, j_next;
    logic             found_reg, found_next;
    logic             drop_merge_reg, drop_merge_next;
    logic             bot_v_reg, bot_v_next;
    logic             rgt_v_reg, rgt_v_next;
    logic [DIM_W-1:0] rw_reg, rw_next;
    logic [DIM_W-1:0] rh_reg, rh_next;
    ent_t             ent_reg, ent_next;
    ent_t             best_reg, best_next;
    ent_t             bot_reg, bot_next;
    ent_t             rgt_reg, rgt_next;
    ent_t             a_reg, a_next;
    logic [PW-1:0]    best_area_reg, best_area_next;
    logic [PW-1:0]    p1_reg, p1_next;
    status_t          res_stat_reg, res_stat_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [1:0]            rsp_stat_reg, rsp_stat_next;
    logic [COORD_BITS-1:0] rsp_x_reg, rsp_x_next;
    logic [COORD_BITS-1:0] rsp_y_reg, rsp_y_next;

    // memory and multiplier ports
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EB-1:0] mem_wdata, mem_rdata;
    logic          mul_en;
    logic [CW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;

    raa_mem #(.DEPTH(MAX_FREE_RECTS), .DW(EB)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    raa_mul #(.W(CW)) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // atlas size clamped to 1 .. 2^COORD_BITS
    logic [CW-1:0] lim, aw_ext, ah_ext;
    logic [FW-1:0] aw_cl, ah_cl;
    ent_t          whole;

    always_comb
    begin
        lim    = CW'(1) << COORD_BITS;
        aw_ext = CW'(atlas_w_reg);
        ah_ext = CW'(atlas_h_reg);
        if (aw_ext == '0)
            aw_cl = FW'(1);
        else if (aw_ext > lim)
            aw_cl = FW'(lim);
        else
            aw_cl = FW'(aw_ext);
        if (ah_ext == '0)
            ah_cl = FW'(1);
        else if (ah_ext > lim)
            ah_cl = FW'(lim);
        else
            ah_cl = FW'(ah_ext);
        whole = '{x: '0, y: '0, w: aw_cl, h: ah_cl};
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= ATLAS_RESET;
            atlas_h_reg <= ATLAS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ATLAS_W: atlas_w_reg <= cfg.data;
                REG_ATLAS_H: atlas_h_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    // per-entry views
    ent_t          rd_ent;
    logic [CW-1:0] rw_c, rh_c;
    logic          exact, fits;
    logic [FW-1:0] rw_f, rh_f;
    logic          hor;
    logic [NW:0]   need;
    logic          joined;
    ent_t          merged;

    always_comb
    begin
        rd_ent = ent_t'(mem_rdata);
        rw_c   = CW'(rw_reg);
        rh_c   = CW'(rh_reg);
        rw_f   = FW'(rw_reg);
        rh_f   = FW'(rh_reg);
        exact  = (rw_c == CW'(ent_reg.w)) && (rh_c == CW'(ent_reg.h));
        fits   = (rw_c <= CW'(ent_reg.w)) && (rh_c <= CW'(ent_reg.h));
        hor    = (p1_reg <= prod);
        need   = (NW+1)'(count_reg) + (NW+1)'(bot_v_reg) + (NW+1)'(rgt_v_reg);

        // edge-adjacent join of a_reg with the entry just read
        joined = 1'b0;
        merged = a_reg;
        if (a_reg.w == rd_ent.w && a_reg.x == rd_ent.x)
        begin
            if ({1'b0, a_reg.y} == {1'b0, rd_ent.y} + {1'b0, rd_ent.h})
            begin
                merged.y = rd_ent.y;
                merged.h = a_reg.h + rd_ent.h;
                joined   = 1'b1;
            end
            else if ({1'b0, a_reg.y} + {1'b0, a_reg.h} == {1'b0, rd_ent.y})
            begin
                merged.h = a_reg.h + rd_ent.h;
                joined   = 1'b1;
            end
        end
        else if (a_reg.h == rd_ent.h && a_reg.y == rd_ent.y)
        begin
            if ({1'b0, a_reg.x} == {1'b0, rd_ent.x} + {1'b0, rd_ent.w})
            begin
                merged.x = rd_ent.x;
                merged.w = a_reg.w + rd_ent.w;
                joined   = 1'b1;
            end
            else if ({1'b0, a_reg.x} + {1'b0, a_reg.w} == {1'b0, rd_ent.x})
            begin
                merged.w = a_reg.w + rd_ent.w;
                joined   = 1'b1;
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_stat_reg;
    assign rsp.place_x = rsp_x_reg;
    assign rsp.place_y = rsp_y_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        best_idx_next   = best_idx_reg;
        drop_t_next     = drop_t_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        drop_merge_next = drop_merge_reg;
        bot_v_next      = bot_v_reg;
        rgt_v_next      = rgt_v_reg;
        rw_next         = rw_reg;
        rh_next         = rh_reg;
        ent_next        = ent_reg;
        best_next       = best_reg;
        bot_next        = bot_reg;
        rgt_next        = rgt_reg;
        a_next          = a_reg;
        best_area_next  = best_area_reg;
        p1_next         = p1_reg;
        res_stat_next   = res_stat_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_stat_next   = rsp_stat_reg;
        rsp_x_next      = rsp_x_reg;
        rsp_y_next      = rsp_y_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = whole;
        mem_re    = 1'b0;
        mem_raddr = '0;
        mul_en    = 1'b0;
        mul_a     = CW'(rd_ent.w);
        mul_b     = CW'(rd_ent.h);

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                count_next = NW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rw_next       = req.req_width;
                    rh_next       = req.req_height;
                    best_next     = '0;
                    res_stat_next = STAT_OK;
                    if (req.command == CMD_CLEAR)
                    begin
                        mem_we     = 1'b1;
                        count_next = NW'(1);
                        state_next = S_DONE;
                    end
                    else if (req.req_width == '0 || req.req_height == '0)
                    begin
                        res_stat_next = STAT_NOFIT;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        k_next     = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (k_reg >= count_reg)
                begin
                    if (found_reg)
                        state_next = S_HOR1;
                    else
                    begin
                        res_stat_next = STAT_NOFIT;
                        best_next     = '0;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = S_SCAN_MUL;
                end
            end
            S_SCAN_MUL:
            begin
                ent_next   = rd_ent;
                mul_en     = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (exact)
                begin
                    best_next     = ent_reg;
                    best_idx_next = k_reg;
                    found_next    = 1'b1;
                    state_next    = S_HOR1;
                end
                else
                begin
                    // same request area for every fit, so compare entry areas
                    if (fits && (!found_reg || prod < best_area_reg))
                    begin
                        best_next      = ent_reg;
                        best_idx_next  = k_reg;
                        best_area_next = prod;
                        found_next     = 1'b1;
                    end
                    k_next     = k_reg + NW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_HOR1:
            begin
                mul_en     = 1'b1;
                mul_a      = rw_c;
                mul_b      = CW'(best_reg.h - rh_f);
                state_next = S_HOR2;
            end
            S_HOR2:
            begin
                p1_next    = prod;
                mul_en     = 1'b1;
                mul_a      = rh_c;
                mul_b      = CW'(best_reg.w - rw_f);
                bot_v_next = (best_reg.h != rh_f);
                rgt_v_next = (best_reg.w != rw_f);
                state_next = S_HOR3;
            end
            S_HOR3:
            begin
                bot_next.x = best_reg.x;
                bot_next.y = best_reg.y + rh_f;
                bot_next.w = hor ? best_reg.w : rw_f;
                bot_next.h = best_reg.h - rh_f;
                rgt_next.x = best_reg.x + rw_f;
                rgt_next.y = best_reg.y;
                rgt_next.w = best_reg.w - rw_f;
                rgt_next.h = hor ? rh_f : best_reg.h;
                if (need > (NW+1)'(MAX_FREE_RECTS) + (NW+1)'(1))
                begin
                    res_stat_next = STAT_FULL;
                    best_next     = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    drop_t_next     = best_idx_reg;
                    drop_merge_next = 1'b0;
                    state_next      = S_DROP_RD;
                end
            end
            S_DROP_RD:
            begin
                if (drop_t_reg + NW'(1) < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(drop_t_reg + NW'(1));
                    state_next = S_DROP_WR;
                end
                else
                begin
                    count_next = count_reg - NW'(1);
                    state_next = drop_merge_reg ? S_MJ_RD : S_APPEND;
                end
            end
            S_DROP_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = drop_t_reg[IW-1:0];
                mem_wdata   = mem_rdata;
                drop_t_next = drop_t_reg + NW'(1);
                state_next  = S_DROP_RD;
            end
            S_APPEND:
            begin
                if (bot_v_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IW-1:0];
                    mem_wdata  = bot_reg;
                    count_next = count_reg + NW'(1);
                    bot_v_next = 1'b0;
                end
                else if (rgt_v_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IW-1:0];
                    mem_wdata  = rgt_reg;
                    count_next = count_reg + NW'(1);
                    rgt_v_next = 1'b0;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_MI_RD;
                end
            end
            S_MI_RD:
            begin
                if (i_reg >= count_reg)
                    state_next = S_DONE;
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg[IW-1:0];
                    state_next = S_MI_LD;
                end
            end
            S_MI_LD:
            begin
                a_next     = rd_ent;
                j_next     = i_reg + NW'(1);
                state_next = S_MJ_RD;
            end
            S_MJ_RD:
            begin
                if (j_reg >= count_reg)
                    state_next = S_MI_WB;
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_reg[IW-1:0];
                    state_next = S_MJ_EV;
                end
            end
            S_MJ_EV:
            begin
                if (joined)
                begin
                    // j stays; later entries shift down over it
                    a_next          = merged;
                    drop_t_next     = j_reg;
                    drop_merge_next = 1'b1;
                    state_next      = S_DROP_RD;
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_MJ_RD;
                end
            end
            S_MI_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[IW-1:0];
                mem_wdata  = a_reg;
                i_next     = i_reg + NW'(1);
                state_next = S_MI_RD;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_stat_next  = res_stat_reg;
                    rsp_x_next     = best_reg.x[COORD_BITS-1:0];
                    rsp_y_next     = best_reg.y[COORD_BITS-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            count_reg      <= NW'(1);
            rsp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            drop_merge_reg <= 1'b0;
            bot_v_reg      <= 1'b0;
            rgt_v_reg      <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            drop_t_reg     <= '0;
            best_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            found_reg      <= found_next;
            drop_merge_reg <= drop_merge_next;
            bot_v_reg      <= bot_v_next;
            rgt_v_reg      <= rgt_v_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            drop_t_reg     <= drop_t_next;
            best_idx_reg   <= best_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg        <= rw_next;
        rh_reg        <= rh_next;
        ent_reg       <= ent_next;
        best_reg      <= best_next;
        bot_reg       <= bot_next;
        rgt_reg       <= rgt_next;
        a_reg         <= a_next;
        best_area_reg <= best_area_next;
        p1_reg        <= p1_next;
        res_stat_reg  <= res_stat_next;
        rsp_stat_reg  <= rsp_stat_next;
        rsp_x_reg     <= rsp_x_next;
        rsp_y_reg     <= rsp_y_next;
    end

    `RAA_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= NW'(MAX_FREE_RECTS), "free count over capacity")
    `RAA_ASSERT_NXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, state_reg != S_IDLE, "ready again right after a request")
    `RAA_ASSERT_IMP(a_best_in_list, clk, rst_n, state_reg == S_HOR1, best_idx_reg < count_reg, "chosen entry outside list")
    `RAA_ASSERT_IMP(a_merge_order, clk, rst_n, state_reg == S_MJ_EV, j_reg > i_reg && j_reg < count_reg, "merge pair out of order")

endmodule
